// ===== sv/jcs_pkg.sv =====
// Shared definitions for the JSON comment stripper.
// Scan mode codes, character constants and the result item type.
// No dependencies.
package jcs_pkg;

    localparam logic [2:0] MODE_OUT   = 3'd0;
    localparam logic [2:0] MODE_SLASH = 3'd1;
    localparam logic [2:0] MODE_LINE  = 3'd2;
    localparam logic [2:0] MODE_BLOCK = 3'd3;
    localparam logic [2:0] MODE_STAR  = 3'd4;
    localparam logic [2:0] MODE_STR   = 3'd5;
    localparam logic [2:0] MODE_ESC   = 3'd6;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;
    localparam int FIFO_CW    = 3;

    typedef struct packed {
        logic [7:0] data;
        logic       byte_valid;
        logic       run_last;
        logic       doc_end;
        logic       strip_error;
    } jcs_result_t;

    function automatic jcs_result_t jcs_byte(input logic [7:0] b);
        jcs_result_t r;
        r             = '0;
        r.data        = b;
        r.byte_valid  = 1'b1;
        return r;
    endfunction

endpackage

// ===== sv/jcs_scan.sv =====
// Scanner for the JSON comment stripper: holds the scan mode and turns one
// input item into zero, one or two result items.
// Depends on jcs_pkg.
module jcs_scan import jcs_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        step,
    input  logic [7:0]  in_byte,
    input  logic        in_last,
    output logic [1:0]  res_count,
    output jcs_result_t res0,
    output jcs_result_t res1
);

    logic [2:0]  mode_reg;
    logic [2:0]  mode_next;
    logic [2:0]  mode_mid;
    jcs_result_t res_c [2];
    logic [1:0]  n_c;
    logic        err_c;

    always_comb begin
        res_c[0] = '0;
        res_c[1] = '0;
        n_c      = 2'd0;
        err_c    = 1'b0;
        mode_mid = mode_reg;

        unique case (mode_reg)
            MODE_SLASH: begin
                if (in_byte == CH_SLASH) begin
                    mode_mid = MODE_LINE;
                end else if (in_byte == CH_STAR) begin
                    mode_mid = MODE_BLOCK;
                end else begin
                    // held slash goes out, then the byte is treated as plain text
                    res_c[0] = jcs_byte(CH_SLASH);
                    n_c      = 2'd1;
                    if (in_byte == CH_SLASH) begin
                        mode_mid = MODE_SLASH;
                    end else begin
                        res_c[1] = jcs_byte(in_byte);
                        n_c      = 2'd2;
                        mode_mid = (in_byte == CH_QUOTE) ? MODE_STR : MODE_OUT;
                    end
                end
            end
            MODE_LINE: begin
                if (in_byte == CH_LF || in_byte == CH_CR) begin
                    res_c[0] = jcs_byte(in_byte);
                    n_c      = 2'd1;
                    mode_mid = MODE_OUT;
                end
            end
            MODE_BLOCK: begin
                if (in_byte == CH_STAR) begin
                    mode_mid = MODE_STAR;
                end
            end
            MODE_STAR: begin
                if (in_byte == CH_SLASH) begin
                    res_c[0] = jcs_byte(CH_SPACE);
                    n_c      = 2'd1;
                    mode_mid = MODE_OUT;
                end else if (in_byte != CH_STAR) begin
                    mode_mid = MODE_BLOCK;
                end
            end
            MODE_STR: begin
                if (in_byte == CH_BSLASH) begin
                    mode_mid = MODE_ESC;
                end else begin
                    res_c[0] = jcs_byte(in_byte);
                    n_c      = 2'd1;
                    if (in_byte == CH_QUOTE) begin
                        mode_mid = MODE_OUT;
                    end
                end
            end
            MODE_ESC: begin
                res_c[0] = jcs_byte(CH_BSLASH);
                res_c[1] = jcs_byte(in_byte);
                n_c      = 2'd2;
                mode_mid = MODE_STR;
            end
            default: begin
                // outside a string; the unused code behaves the same
                if (in_byte == CH_SLASH) begin
                    mode_mid = MODE_SLASH;
                end else begin
                    res_c[0] = jcs_byte(in_byte);
                    n_c      = 2'd1;
                    mode_mid = (in_byte == CH_QUOTE) ? MODE_STR : MODE_OUT;
                end
            end
        endcase

        mode_next = mode_mid;
        if (in_last) begin
            // n_c is at most one whenever a slash is still held here
            if (mode_mid == MODE_SLASH) begin
                res_c[n_c[0]] = jcs_byte(CH_SLASH);
                n_c           = n_c + 2'd1;
            end
            err_c = (mode_mid == MODE_BLOCK) || (mode_mid == MODE_STAR) ||
                    (mode_mid == MODE_ESC);
            mode_next = MODE_OUT;
            if (n_c == 2'd0) begin
                n_c = 2'd1;
            end
            res_c[n_c[1]].doc_end     = 1'b1;
            res_c[n_c[1]].strip_error = err_c;
        end
        if (n_c != 2'd0) begin
            res_c[n_c[1]].run_last = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_OUT;
        end else if (step) begin
            mode_reg <= mode_next;
        end
    end

    assign res_count = n_c;
    assign res0      = res_c[0];
    assign res1      = res_c[1];

    // end of document always leaves the scanner outside a string
    a_doc_resets_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        step && in_last |=> mode_reg == MODE_OUT)
        else $error("scan mode not cleared after document end");

    // a byte that is not last yields at most one result unless something was held
    a_pair_only_when_held: assert property (@(posedge aclk) disable iff (!aresetn)
        step && !in_last && res_count == 2'd2 |->
            mode_reg == MODE_SLASH || mode_reg == MODE_ESC)
        else $error("two results without a held slash or backslash");

endmodule

// ===== sv/json_comment_stripper_top.sv =====
// Top level of the JSON comment stripper: input register, scanner and a
// small result queue in front of the output channel.
// Depends on jcs_pkg and jcs_scan.
//
//  channel | dir | tdata            | tuser                                   | tlast
//  s_      | in  | [7:0] in_byte    | -                                       | in_last
//  m_      | out | [7:0] out_byte   | [0] byte_valid [1] run_last [2] strip_error | doc_end
//
// One byte per cycle is taken while the queue has room; the scanner works on the registered
// byte and pushes up to two items into a four-entry result queue.
// A byte waits in the input register while the queue has fewer than two
// free entries.
// Synchronous active-low reset empties the queue and returns the scan mode
// to outside string. Either side may stall at any time.
module json_comment_stripper_top import jcs_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic [2:0] m_tuser,   // [0] byte_valid, [1] run_last, [2] strip_error
    output logic       m_tlast
);

    logic               in_valid_reg;
    logic [7:0]         in_byte_reg;
    logic               in_last_reg;
    logic               drain;
    logic               pop;
    logic [1:0]         res_count;
    logic [1:0]         push_n;
    jcs_result_t        res0;
    jcs_result_t        res1;
    jcs_result_t        fifo_reg [FIFO_DEPTH];
    jcs_result_t        head;
    logic [FIFO_AW-1:0] wr_reg;
    logic [FIFO_AW-1:0] rd_reg;
    logic [FIFO_CW-1:0] count_reg;
    logic [FIFO_CW-1:0] count_next;

    assign drain    = in_valid_reg && (count_reg <= FIFO_CW'(FIFO_DEPTH - 2));
    assign s_tready = !in_valid_reg || drain;
    assign pop      = m_tvalid && m_tready;
    assign push_n   = drain ? res_count : 2'd0;

    jcs_scan u_scan (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (drain),
        .in_byte   (in_byte_reg),
        .in_last   (in_last_reg),
        .res_count (res_count),
        .res0      (res0),
        .res1      (res1)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    assign count_next = count_reg + FIFO_CW'(push_n) - FIFO_CW'(pop);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end else begin
            wr_reg    <= wr_reg + FIFO_AW'(push_n);
            rd_reg    <= rd_reg + FIFO_AW'(pop);
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_n != 2'd0) begin
            fifo_reg[wr_reg] <= res0;
        end
        if (push_n == 2'd2) begin
            fifo_reg[FIFO_AW'(wr_reg + 1'b1)] <= res1;
        end
    end

    assign head     = fifo_reg[rd_reg];
    assign m_tvalid = (count_reg != '0);
    assign m_tdata  = head.data;
    assign m_tuser  = {head.strip_error, head.run_last, head.byte_valid};
    assign m_tlast  = head.doc_end;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= FIFO_CW'(FIFO_DEPTH))
        else $error("result queue overflow");

    a_doc_end_closes_run: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tuser[1])
        else $error("document end item does not close its run");

    a_error_only_at_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[2] |-> m_tlast)
        else $error("strip error outside document end");

    a_empty_item_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata == 8'h00 && m_tlast)
        else $error("item without a byte carries data or is not a document end");

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking bench for json_comment_stripper_top: byte stream in, stripped items out.
// Expected items come from a behavioural scanner kept in step with every accepted byte.
// Depends on jcs_pkg and the RTL top level.
module testbench import jcs_pkg::*; ();

    localparam int CYCLE_LIMIT  = 200000;
    localparam int LONG_HOLD    = 64;
    localparam int DRAIN_CYCLES = 8;
    localparam logic [7:0] SPECIALS [7] = '{CH_QUOTE, CH_SLASH, CH_STAR, CH_BSLASH,
                                            CH_LF, CH_CR, CH_SPACE};
    localparam string PUNCT = "{}[]:, \t\n0123456789eE.-+truefalsn";

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;
    logic       s_tlast  = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic [2:0] m_tuser;
    logic       m_tlast;

    jcs_result_t stripped_q [$];     // items still owed by the block
    logic [7:0]  doc_q [$];          // document being sent
    logic [2:0]  lexer_state = MODE_OUT;
    jcs_result_t seen, want;

    bit src_idle_on   = 1'b1;
    bit sink_idle_on  = 1'b1;
    bit sink_hold_req = 1'b0;
    int cycle_count   = 0;
    int fail_count    = 0;
    int bytes_in      = 0;
    int items_out     = 0;
    int docs_done     = 0;
    int docs_flagged  = 0;

    json_comment_stripper_top u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #1 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d items outstanding",
                     cycle_count, stripped_q.size());
            $display("json_comment_stripper_top regression: fail");
            $finish;
        end
    end

    function automatic void doc_add(input logic [7:0] b);
        doc_q.insert(doc_q.size(), b);
    endfunction

    // scanner state advanced once per accepted byte; queues the items it owes
    function automatic void predict_stripped(input logic [7:0] b, input logic last);
        logic [7:0]  emitted [$];
        logic [2:0]  next_mode;
        logic        plain;
        logic        err;
        jcs_result_t item;
        next_mode = lexer_state;
        plain     = 1'b0;
        err       = 1'b0;
        case (lexer_state)
            MODE_SLASH: begin
                if (b == CH_SLASH) next_mode = MODE_LINE;
                else if (b == CH_STAR) next_mode = MODE_BLOCK;
                else begin
                    emitted.insert(emitted.size(), CH_SLASH);
                    plain = 1'b1;
                end
            end
            MODE_LINE: begin
                if (b == CH_LF || b == CH_CR) begin
                    emitted.insert(emitted.size(), b);
                    next_mode = MODE_OUT;
                end
            end
            MODE_BLOCK: begin
                if (b == CH_STAR) next_mode = MODE_STAR;
            end
            MODE_STAR: begin
                if (b == CH_SLASH) begin
                    emitted.insert(emitted.size(), CH_SPACE);
                    next_mode = MODE_OUT;
                end else if (b != CH_STAR) begin
                    next_mode = MODE_BLOCK;
                end
            end
            MODE_STR: begin
                if (b == CH_BSLASH) next_mode = MODE_ESC;
                else begin
                    emitted.insert(emitted.size(), b);
                    if (b == CH_QUOTE) next_mode = MODE_OUT;
                end
            end
            MODE_ESC: begin
                emitted.insert(emitted.size(), CH_BSLASH);
                emitted.insert(emitted.size(), b);
                next_mode = MODE_STR;
            end
            default: plain = 1'b1;   // outside string; the spare code behaves the same
        endcase
        if (plain) begin
            if (b == CH_SLASH) next_mode = MODE_SLASH;
            else begin
                emitted.insert(emitted.size(), b);
                next_mode = (b == CH_QUOTE) ? MODE_STR : MODE_OUT;
            end
        end
        if (last) begin
            // a held slash is flushed; a held backslash is dropped and flagged
            if (next_mode == MODE_SLASH && emitted.size() < 2)
                emitted.insert(emitted.size(), CH_SLASH);
            err = (next_mode == MODE_BLOCK || next_mode == MODE_STAR || next_mode == MODE_ESC);
            next_mode = MODE_OUT;
            docs_done++;
            if (err) docs_flagged++;
        end
        lexer_state = next_mode;
        if (last && emitted.size() == 0) begin
            item             = '0;
            item.run_last    = 1'b1;
            item.doc_end     = 1'b1;
            item.strip_error = err;
            stripped_q.insert(stripped_q.size(), item);
        end
        foreach (emitted[i]) begin
            item            = '0;
            item.data       = emitted[i];
            item.byte_valid = 1'b1;
            if (i == emitted.size() - 1) begin
                item.run_last    = 1'b1;
                item.doc_end     = last;
                item.strip_error = err;
            end
            stripped_q.insert(stripped_q.size(), item);
        end
    endfunction

    task automatic report_mismatch(input string what, input int got, input int exp_val);
        $display("MISMATCH at cycle %0d, item %0d: %s got %0h expected %0h",
                 cycle_count, items_out, what, got, exp_val);
        fail_count++;
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            seen.data        = m_tdata;
            seen.byte_valid  = m_tuser[0];
            seen.run_last    = m_tuser[1];
            seen.strip_error = m_tuser[2];
            seen.doc_end     = m_tlast;
            if (stripped_q.size() == 0) begin
                report_mismatch("unexpected item, data", seen.data, 0);
            end else begin
                want = stripped_q.pop_front();
                if (seen.data != want.data)
                    report_mismatch("out_byte", seen.data, want.data);
                if (seen.byte_valid != want.byte_valid)
                    report_mismatch("byte_valid", seen.byte_valid, want.byte_valid);
                if (seen.run_last != want.run_last)
                    report_mismatch("run_last", seen.run_last, want.run_last);
                if (seen.doc_end != want.doc_end)
                    report_mismatch("doc_end", seen.doc_end, want.doc_end);
                if (seen.strip_error != want.strip_error)
                    report_mismatch("strip_error", seen.strip_error, want.strip_error);
            end
            items_out++;
        end
    end

    // receiver: random ready bursts, plus one long hold on request
    initial begin
        forever begin
            @(posedge aclk);
            if (sink_hold_req) begin
                sink_hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (LONG_HOLD - 1) @(posedge aclk);
            end else if (sink_idle_on && $urandom_range(0, 7) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(0, 5)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        if (src_idle_on && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_stripped(b, last);
        bytes_in++;
    endtask

    task automatic send_text(input string s, input bit end_doc);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], end_doc && (i == s.len() - 1));
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (stripped_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // JSON-like text with strings, escapes, both comment kinds and lone slashes
    function automatic void compose_document(input bit broken);
        logic [7:0] c;
        int         keep;
        doc_q.delete();
        repeat ($urandom_range(3, 12)) begin
            case ($urandom_range(0, 6))
                0: doc_add(PUNCT[$urandom_range(0, PUNCT.len() - 1)]);
                1, 2: begin
                    doc_add(CH_QUOTE);
                    repeat ($urandom_range(0, 6)) begin
                        c = 8'($urandom_range(0, 255));
                        if ($urandom_range(0, 3) == 0) begin
                            doc_add(CH_BSLASH);
                            doc_add(c);
                        end else begin
                            doc_add((c == CH_QUOTE || c == CH_BSLASH) ? 8'("x") : c);
                        end
                    end
                    doc_add(CH_QUOTE);
                end
                3: begin
                    doc_add(CH_SLASH);
                    doc_add(CH_SLASH);
                    repeat ($urandom_range(0, 5)) begin
                        c = 8'($urandom_range(0, 255));
                        doc_add((c == CH_LF || c == CH_CR) ? 8'("#") : c);
                    end
                    doc_add($urandom_range(0, 1) ? CH_LF : CH_CR);
                end
                4: begin
                    doc_add(CH_SLASH);
                    doc_add(CH_STAR);
                    repeat ($urandom_range(0, 6))
                        doc_add($urandom_range(0, 2) == 0 ? CH_STAR
                                                          : 8'($urandom_range(0, 255)));
                    doc_add(CH_STAR);
                    doc_add(CH_SLASH);
                end
                5: begin
                    doc_add(CH_SLASH);
                    doc_add(PUNCT[$urandom_range(0, PUNCT.len() - 1)]);
                end
                default: doc_add(8'($urandom_range(0, 255)));
            endcase
        end
        // broken documents stop anywhere, often mid comment or mid escape
        if (broken) begin
            keep = $urandom_range(1, doc_q.size());
            while (doc_q.size() > keep) void'(doc_q.pop_back());
        end
    endfunction

    task automatic send_document();
        foreach (doc_q[i]) send_byte(doc_q[i], i == doc_q.size() - 1);
    endtask

    task automatic test_directed_cases();
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_text("/x//c", 1'b0);          // lone slash, then line comment
        send_byte(CH_CR, 1'b0);
        send_text("/***/\"\\q\"", 1'b1);   // block comment with extra stars, escaped pair
        send_text("/", 1'b1);              // slash held at end is flushed
        send_text("\"\\", 1'b1);           // dangling escape
        send_text("/*x", 1'b1);            // open block comment
        send_text("//", 1'b1);             // nothing to emit at end
        send_text("\"a", 1'b1);            // open string is fine
        wait_drained();
    endtask

    task automatic test_random_documents(input int target);
        int start;
        start = bytes_in;
        while (bytes_in - start < target) begin
            compose_document($urandom_range(0, 4) == 0);
            send_document();
        end
        wait_drained();
    endtask

    task automatic test_byte_noise(input int count);
        repeat (count) begin
            send_byte($urandom_range(0, 1) ? SPECIALS[$urandom_range(0, 6)]
                                           : 8'($urandom_range(0, 255)),
                      $urandom_range(0, 19) == 0);
        end
        send_byte(CH_SPACE, 1'b1);
        wait_drained();
    endtask

    // the second byte of an escape gives two items, so the queue fills while the sink holds off
    task automatic test_output_backpressure();
        src_idle_on   = 1'b0;
        sink_hold_req = 1'b1;
        send_byte(CH_QUOTE, 1'b0);
        repeat (19) begin
            send_byte(CH_BSLASH, 1'b0);
            send_byte(8'($urandom_range(0, 255)), 1'b0);
        end
        send_byte(CH_QUOTE, 1'b1);
        wait_drained();
        src_idle_on = 1'b1;
    endtask

    task automatic test_unbroken_stream(input int target);
        int start;
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        start = bytes_in;
        while (bytes_in - start < target) begin
            compose_document(1'b0);
            send_document();
        end
        wait_drained();
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_cases();
        test_random_documents(1150);
        test_byte_noise(300);
        test_output_backpressure();
        test_unbroken_stream(150);
        $display("covered %0d input bytes and %0d output items over %0d documents",
                 bytes_in, items_out, docs_done);
        $display("%0d documents ended with an open block comment or escape, %0d mismatches",
                 docs_flagged, fail_count);
        if (fail_count == 0)
            $display("json_comment_stripper_top regression: pass");
        else
            $display("json_comment_stripper_top regression: fail");
        $finish;
    end

endmodule
